[rtl/crp_pkg.sv]
// Shared types and constants for the cell reference parser.
`timescale 1ns / 1ps

package crp_pkg;

  // Width of the column and row accumulators; values above 2**NUMBER_BITS-1 overflow.
  localparam int NUMBER_BITS = 31;
  // Fixed width of the column and row result fields.
  localparam int OUT_BITS    = 31;

  // Number bases of the column letters and the row digits.
  localparam int COL_BASE  = 26;
  localparam int ROW_BASE  = 10;
  // Widths that hold acc * base + add without loss.
  localparam int COL_W     = NUMBER_BITS + 5;
  localparam int ROW_W     = NUMBER_BITS + 4;

  // Character codes.
  localparam logic [7:0] CHR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Character classes.
  typedef enum logic [1:0] {
    CLS_DOLLAR = 2'd0,
    CLS_LETTER = 2'd1,
    CLS_DIGIT  = 2'd2,
    CLS_OTHER  = 2'd3
  } char_class_t;

  // Decoded character: class and its value (letter 1..26 or digit 0..9).
  typedef struct packed {
    char_class_t cls;
    logic [4:0]  value;
  } char_info_t;

  // Running parse state.
  typedef struct packed {
    logic [NUMBER_BITS-1:0] col_acc;
    logic [NUMBER_BITS-1:0] row_acc;
    logic                   letters_seen;
    logic                   digits_seen;
    logic                   col_dollar;
    logic                   row_dollar;
    logic                   row_dollar_taken;
    status_t                error_code;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [OUT_BITS-1:0] column_number;
    logic [OUT_BITS-1:0] row_number;
    logic                absolute_column;
    logic                absolute_row;
  } result_t;

endpackage

[rtl/crp_classify.sv]
// Character decoder: sorts a byte into dollar, letter, digit or other and gives its value.
`timescale 1ns / 1ps

module crp_classify import crp_pkg::*; (
  input  logic [7:0] character,
  output char_info_t info
);

  // Upper and lower case letters map to 1..26, digits to 0..9.
  always_comb begin
    info.cls   = CLS_OTHER;
    info.value = '0;
    if (character == CHR_DOLLAR) begin
      info.cls = CLS_DOLLAR;
    end else if (character >= CHR_UPPER_A && character <= CHR_UPPER_Z) begin
      info.cls   = CLS_LETTER;
      info.value = 5'(character - CHR_UPPER_A + 8'd1);
    end else if (character >= CHR_LOWER_A && character <= CHR_LOWER_Z) begin
      info.cls   = CLS_LETTER;
      info.value = 5'(character - CHR_LOWER_A + 8'd1);
    end else if (character >= CHR_ZERO && character <= CHR_NINE) begin
      info.cls   = CLS_DIGIT;
      info.value = 5'(character - CHR_ZERO);
    end
  end

endmodule

[rtl/crp_core.sv]
// Parse state registers and the per-item update of flags, accumulators and result.
`timescale 1ns / 1ps

module crp_core import crp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  char_info_t info,
  input  logic       last,
  output result_t    result
);

  parse_state_t state;
  parse_state_t state_next;
  logic [COL_W-1:0] col_sum;
  logic [ROW_W-1:0] row_sum;
  logic             col_ovf;
  logic             row_ovf;

  // Multiply-add of each accumulator, with the overflow taken from the carry bits.
  assign col_sum = COL_W'(state.col_acc) * COL_W'(COL_BASE) + COL_W'(info.value);
  assign row_sum = ROW_W'(state.row_acc) * ROW_W'(ROW_BASE) + ROW_W'(info.value);
  assign col_ovf = |col_sum[COL_W-1:NUMBER_BITS];
  assign row_ovf = |row_sum[ROW_W-1:NUMBER_BITS];

  // Apply one character; the first error freezes the state until the last item.
  always_comb begin
    parse_state_t upd;
    status_t      st;
    upd = state;
    if (state.error_code == ST_OK) begin
      case (info.cls)
        CLS_DOLLAR: begin
          if (!state.letters_seen && !state.digits_seen) begin
            upd.col_dollar = 1'b1;
          end else if (state.letters_seen && !state.digits_seen &&
                       !state.row_dollar_taken) begin
            upd.row_dollar       = 1'b1;
            upd.row_dollar_taken = 1'b1;
          end else begin
            upd.error_code = ST_INVALID;
          end
        end
        CLS_LETTER: begin
          if (state.digits_seen || state.row_dollar_taken) begin
            upd.error_code = ST_INVALID;
          end else begin
            upd.letters_seen = 1'b1;
            if (col_ovf) begin
              upd.error_code = ST_OVERFLOW;
            end else begin
              upd.col_acc = col_sum[NUMBER_BITS-1:0];
            end
          end
        end
        CLS_DIGIT: begin
          if (!state.letters_seen) begin
            upd.error_code = ST_INVALID;
          end else begin
            upd.digits_seen = 1'b1;
            if (row_ovf) begin
              upd.error_code = ST_OVERFLOW;
            end else begin
              upd.row_acc = row_sum[NUMBER_BITS-1:0];
            end
          end
        end
        default: begin
          upd.error_code = ST_INVALID;
        end
      endcase
    end

    // Build the result; a reference with no digits is invalid.
    st = upd.error_code;
    if (st == ST_OK && !upd.digits_seen) begin
      st = ST_INVALID;
    end
    result.status = st;
    if (st == ST_OK) begin
      result.column_number   = OUT_BITS'(upd.col_acc);
      result.row_number      = OUT_BITS'(upd.row_acc);
      result.absolute_column = upd.col_dollar;
      result.absolute_row    = upd.row_dollar;
    end else begin
      result.column_number   = '0;
      result.row_number      = '0;
      result.absolute_column = 1'b0;
      result.absolute_row    = 1'b0;
    end

    // The last item of a reference clears the state.
    state_next = last ? '0 : upd;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

[rtl/cell_reference_parser.sv]
// Top level of the cell reference parser: input register, parse core and result register.
`timescale 1ns / 1ps

// Parses an A1-style cell reference such as $AB$12, one character per item, with
// last_char set on the final character. One item is accepted every clock cycle while
// in_stall is low; the result of a reference is loaded into the result register when
// its last item leaves the input register, and it is held while out_stall is high.
// The rate is set by the state update loop, a combinational constant multiply-add on
// the column or row accumulator. in_stall rises only when a last item waits in the
// input register behind a result that is not yet taken. status is 0 for ok, 1 for an
// invalid reference (bad character order, stray character or no row digits) and 2
// when the column or row exceeds 31 bits; on a nonzero status all other result
// fields are zero.
module cell_reference_parser import crp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          character,
  input  logic                last_char,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [OUT_BITS-1:0] column_number,
  output logic [OUT_BITS-1:0] row_number,
  output logic                absolute_column,
  output logic                absolute_row
);

  logic       in_reg_valid;
  logic [7:0] in_reg_char;
  logic       in_reg_last;
  logic       out_free;
  logic       advance;
  char_info_t info;
  result_t    result;
  result_t    out_reg;

  // The held item moves on unless it carries a result and the result register is full.
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && (!in_reg_last || out_free);
  assign in_stall = in_reg_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_char <= character;
      in_reg_last <= last_char;
    end
  end

  crp_classify u_classify (
    .character (in_reg_char),
    .info      (info)
  );

  crp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .info    (info),
    .last    (in_reg_last),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && in_reg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_last) begin
      out_reg <= result;
    end
  end

  assign status          = out_reg.status;
  assign column_number   = out_reg.column_number;
  assign row_number      = out_reg.row_number;
  assign absolute_column = out_reg.absolute_column;
  assign absolute_row    = out_reg.absolute_row;

endmodule

[rtl/crp_checker.sv]
// Port-level checks for the cell reference parser and their binding to the top level.
`timescale 1ns / 1ps

module crp_checker import crp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          status,
  input logic [OUT_BITS-1:0] column_number,
  input logic [OUT_BITS-1:0] row_number,
  input logic                absolute_column,
  input logic                absolute_row
);

  // A stalled result item stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(column_number) &&
      $stable(row_number) && $stable(absolute_column) && $stable(absolute_row))
    else $error("result item changed while stalled");

  // A failed parse reports no column, row or flags.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> column_number == '0 && row_number == '0 &&
      !absolute_column && !absolute_row)
    else $error("error result carries nonzero fields");

  // Reset empties both the input and the result registers.
  assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind cell_reference_parser crp_checker u_crp_checker (.*);

[dv/tb.sv]
// Testbench for the cell reference parser: directed and random references checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import crp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_CHARS = 700;

  // Holds the parse state of the reference under way and the results it must produce.
  class ref_scoreboard;
    logic [NUMBER_BITS-1:0] col_acc;
    logic [NUMBER_BITS-1:0] row_acc;
    logic                   letters_seen;
    logic                   digits_seen;
    logic                   col_dollar;
    logic                   row_dollar;
    logic                   row_dollar_taken;
    status_t                parse_err;
    result_t                expected_q[$];
    int                     errors;
    int                     n_refs;
    int                     n_ok;
    int                     n_invalid;
    int                     n_overflow;

    function new();
      clear();
      errors     = 0;
      n_refs     = 0;
      n_ok       = 0;
      n_invalid  = 0;
      n_overflow = 0;
    endfunction

    function void clear();
      col_acc          = '0;
      row_acc          = '0;
      letters_seen     = 1'b0;
      digits_seen      = 1'b0;
      col_dollar       = 1'b0;
      row_dollar       = 1'b0;
      row_dollar_taken = 1'b0;
      parse_err        = ST_OK;
    endfunction

    // True when acc * base + add stays within NUMBER_BITS.
    function bit fits(longint unsigned acc, longint unsigned base, longint unsigned add);
      longint unsigned lim;
      lim = (64'd1 << NUMBER_BITS) - 64'd1;
      return acc <= (lim - add) / base;
    endfunction

    // Applies one character to the running state.
    function void absorb(logic [7:0] ch);
      logic            is_upper;
      logic            is_lower;
      logic            is_digit;
      longint unsigned v;
      longint unsigned t;
      is_upper = (ch >= CHR_UPPER_A) && (ch <= CHR_UPPER_Z);
      is_lower = (ch >= CHR_LOWER_A) && (ch <= CHR_LOWER_Z);
      is_digit = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
      if (ch == CHR_DOLLAR) begin
        if (!letters_seen && !digits_seen) begin
          col_dollar = 1'b1;
        end else if (letters_seen && !digits_seen && !row_dollar_taken) begin
          row_dollar       = 1'b1;
          row_dollar_taken = 1'b1;
        end else begin
          parse_err = ST_INVALID;
        end
      end else if (is_upper || is_lower) begin
        v = is_upper ? longint'(ch - CHR_UPPER_A) + 1 : longint'(ch - CHR_LOWER_A) + 1;
        if (digits_seen || row_dollar_taken) begin
          parse_err = ST_INVALID;
        end else begin
          letters_seen = 1'b1;
          if (fits(col_acc, COL_BASE, v)) begin
            t       = longint'(col_acc) * COL_BASE + v;
            col_acc = t[NUMBER_BITS-1:0];
          end else begin
            parse_err = ST_OVERFLOW;
          end
        end
      end else if (is_digit) begin
        v = longint'(ch - CHR_ZERO);
        if (!letters_seen) begin
          parse_err = ST_INVALID;
        end else begin
          digits_seen = 1'b1;
          if (fits(row_acc, ROW_BASE, v)) begin
            t       = longint'(row_acc) * ROW_BASE + v;
            row_acc = t[NUMBER_BITS-1:0];
          end else begin
            parse_err = ST_OVERFLOW;
          end
        end
      end else begin
        parse_err = ST_INVALID;
      end
    endfunction

    // Notes an accepted character; the last one of a reference queues its result.
    function void note_char(logic [7:0] ch, logic last);
      result_t r;
      status_t st;
      // Once an error is recorded the rest of the reference is ignored.
      if (parse_err == ST_OK) absorb(ch);
      if (last) begin
        st = parse_err;
        if (st == ST_OK && !digits_seen) st = ST_INVALID;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
          r.column_number   = col_acc;
          r.row_number      = row_acc;
          r.absolute_column = col_dollar;
          r.absolute_row    = row_dollar;
          n_ok++;
        end else if (st == ST_INVALID) begin
          n_invalid++;
        end else begin
          n_overflow++;
        end
        expected_q.insert(expected_q.size(), r);
        n_refs++;
        clear();
      end
    endfunction

    // Compares one result item with the oldest expectation.
    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d col=%0d row=%0d absc=%0d absr=%0d",
                 $time, got.status, got.column_number, got.row_number,
                 got.absolute_column, got.absolute_row);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected status=%0d col=%0d row=%0d absc=%0d absr=%0d",
                 $time, exp_r.status, exp_r.column_number, exp_r.row_number,
                 exp_r.absolute_column, exp_r.absolute_row);
        $display("%0t:          actual   status=%0d col=%0d row=%0d absc=%0d absr=%0d",
                 $time, got.status, got.column_number, got.row_number,
                 got.absolute_column, got.absolute_row);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          character = 8'h00;
  logic                last_char = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [OUT_BITS-1:0] column_number;
  logic [OUT_BITS-1:0] row_number;
  logic                absolute_column;
  logic                absolute_row;

  ref_scoreboard board = new();
  logic [7:0]    cell_text[$];
  int            sent_chars = 0;
  int            cycle_count = 0;
  int            stall_pct = 0;
  int            hold_left = 0;
  int            hold_pick;

  cell_reference_parser DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .character       (character),
    .last_char       (last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .column_number   (column_number),
    .row_number      (row_number),
    .absolute_column (absolute_column),
    .absolute_row    (absolute_row)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: check accepted items and drive a random stall.
  always @(posedge clk) begin
    result_t got;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      got.status          = status_t'(status);
      got.column_number   = column_number;
      got.row_number      = row_number;
      got.absolute_column = absolute_column;
      got.absolute_row    = absolute_row;
      board.check_result(got);
    end
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      hold_pick = $urandom_range(0, 99);
      hold_left = (hold_pick < 85) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end
  end

  // Appends one character to the reference under construction.
  function automatic void add_char(logic [7:0] c);
    cell_text.insert(cell_text.size(), c);
  endfunction

  // Sends the characters of cell_text as one reference, last flag on the final one.
  task automatic send_text(bit no_gaps);
    int gap;
    int pick;
    for (int i = 0; i < cell_text.size(); i++) begin
      if (!no_gaps) begin
        pick = $urandom_range(0, 99);
        gap  = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid  <= 1'b1;
      character <= cell_text[i];
      last_char <= (i == cell_text.size() - 1);
      do @(posedge clk); while (in_stall);
      board.note_char(cell_text[i], i == cell_text.size() - 1);
      sent_chars++;
    end
  endtask

  task automatic send_string(string s);
    cell_text.delete();
    foreach (s[i]) add_char(s[i]);
    send_text(1'b0);
  endtask

  // Builds a random reference: mostly well formed, some broken or pure noise.
  function automatic void build_reference();
    int    n;
    int    r;
    int    pos;
    string row_s;
    cell_text.delete();
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 85) ? 1 : $urandom_range(2, 3);
    repeat (n) add_char(CHR_DOLLAR);
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(1, 3) : (r < 90) ? $urandom_range(4, 6) : $urandom_range(7, 8);
    repeat (n) begin
      add_char(($urandom_range(0, 1) ? CHR_LOWER_A : CHR_UPPER_A) +
               8'($urandom_range(0, 25)));
    end
    if ($urandom_range(0, 1)) add_char(CHR_DOLLAR);
    // Rows at the edge of the 31-bit range, otherwise random digit strings.
    r = $urandom_range(0, 99);
    if (r < 6) begin
      row_s = $urandom_range(0, 1) ? "2147483647" : "2147483648";
      foreach (row_s[i]) add_char(row_s[i]);
    end else begin
      n = (r < 70) ? $urandom_range(1, 4) : (r < 90) ? $urandom_range(5, 9) : $urandom_range(10, 11);
      repeat (n) add_char(CHR_ZERO + 8'($urandom_range(0, 9)));
    end
    // Break a share of the references.
    r = $urandom_range(0, 99);
    if (r < 8) begin
      pos = $urandom_range(0, cell_text.size() - 1);
      cell_text[pos] = 8'($urandom_range(0, 255));
    end else if (r < 14) begin
      pos = $urandom_range(0, cell_text.size());
      cell_text.insert(pos, 8'($urandom_range(0, 255)));
    end else if (r < 18) begin
      while (cell_text[cell_text.size() - 1] >= CHR_ZERO &&
             cell_text[cell_text.size() - 1] <= CHR_NINE) begin
        void'(cell_text.pop_back());
      end
    end else if (r < 25) begin
      cell_text.delete();
      n = $urandom_range(1, 5);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: add_char(CHR_DOLLAR);
          1: add_char(CHR_UPPER_A + 8'($urandom_range(0, 25)));
          2: add_char(CHR_ZERO + 8'($urandom_range(0, 9)));
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endfunction

  // Stops a run that hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[cell_reference_parser] ERROR");
    $finish;
  end

  initial begin
    int refs_sent;
    int pct_pick;
    refs_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed references: flags, both cases, ordering rules and stray bytes.
    send_string("$A$1");
    send_string("z0");
    send_string("$$Z7");
    send_string("7");
    send_string("Q");
    send_string("A1$");
    send_string("B$$2");
    send_string("C$d1");
    send_string("E5f");
    send_string("%A1");
    cell_text = '{8'hFF};
    send_text(1'b0);
    cell_text = '{8'h00};
    send_text(1'b0);

    // Random references, with the result-side stall changing every few dozen.
    while (sent_chars < TARGET_CHARS) begin
      if (refs_sent % 40 == 0) begin
        pct_pick  = $urandom_range(0, 2);
        stall_pct = (pct_pick == 0) ? 0 : (pct_pick == 1) ? 25 : 60;
      end
      build_reference();
      send_text($urandom_range(0, 4) == 0);
      refs_sent++;
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Parsed %0d references from %0d characters: %0d ok, %0d invalid, %0d overflow.",
             board.n_refs, sent_chars, board.n_ok, board.n_invalid, board.n_overflow);
    if (board.errors == 0) begin
      $display("[cell_reference_parser] OK");
    end else begin
      $display("%0d result errors.", board.errors);
      $display("[cell_reference_parser] ERROR");
    end
    $finish;
  end

endmodule
